@@ sv/pqd_pkg.sv @@
// Package for the product-quantization distance engine: field widths, stream
// layout offsets, opcode type and parameter defaults.
// No dependencies.
`default_nettype none

package pqd_pkg;

    localparam int NUM_SUBQUANTIZERS_DEF = 16;
    localparam int CODES_PER_TABLE_DEF   = 256;

    localparam int ID_W      = 32;
    localparam int CODE_W    = 8;
    localparam int CODES_W   = 64;
    localparam int TSEL_W    = 4;
    localparam int EIDX_W    = 8;
    localparam int ENTRY_W   = 32;
    localparam int DIST_W    = 36;
    localparam int FRAC_W    = 16;
    localparam int CODES_PER_WORD = CODES_W / CODE_W;

    localparam int S_ID_LSB    = 0;
    localparam int S_CLO_LSB   = S_ID_LSB + ID_W;
    localparam int S_CHI_LSB   = S_CLO_LSB + CODES_W;
    localparam int S_TSEL_LSB  = S_CHI_LSB + CODES_W;
    localparam int S_EIDX_LSB  = S_TSEL_LSB + TSEL_W;
    localparam int S_EVAL_LSB  = S_EIDX_LSB + EIDX_W;
    localparam int S_USED_W    = S_EVAL_LSB + ENTRY_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    localparam int M_ID_LSB    = 0;
    localparam int M_DIST_LSB  = M_ID_LSB + ID_W;
    localparam int M_USED_W    = M_DIST_LSB + DIST_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } pqd_op_t;

endpackage

`default_nettype wire

@@ sv/pqd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enable-held read data output. No dependencies.
`default_nettype none

module pqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/pq_distance_lookup_sum.sv @@
// Top level of the product-quantization distance engine: per-table RAMs,
// reset fill sequencer and a registered adder tree. Uses pqd_pkg, pqd_ram.
//
// Channel  Dir  Handshake           Contents
// s_       in   s_tvalid/s_tready   tuser: opcode; tdata: id, codes, write entry
// m_       out  m_tvalid/m_tready   tdata: result_id, distance
//
// One transaction per cycle while m_tready is high and no fill runs; a lookup
// reaches m_ through the RAM read register (loaded at the accepting edge) and
// three registered adder-tree levels. Writes produce nothing.
// After reset a fill pass writes the initial pattern, one row across all
// tables per cycle, over all CODES_PER_TABLE rows with s_tready low.
// Each stage holds only while the stage after it is full and stalled.
`default_nettype none

module pq_distance_lookup_sum #(
    parameter int NUM_SUBQUANTIZERS = pqd_pkg::NUM_SUBQUANTIZERS_DEF,
    parameter int CODES_PER_TABLE   = pqd_pkg::CODES_PER_TABLE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // vector_id, codes_low, codes_high, table_select, entry_index, entry_value
    input  logic [pqd_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_id, distance
    output logic [pqd_pkg::M_TDATA_W-1:0] m_tdata
);

    import pqd_pkg::*;

    localparam int NSQ  = NUM_SUBQUANTIZERS;
    localparam int AW   = $clog2(CODES_PER_TABLE);
    localparam int G1   = (NSQ + 3) / 4;
    localparam int G2   = (G1 + 3) / 4;
    localparam int L1_W = ENTRY_W + 2;
    localparam int L2_W = ENTRY_W + 4;
    localparam int L3_W = ENTRY_W + 6;
    localparam int INT_W = ENTRY_W - FRAC_W;

    logic              init_busy_reg, init_busy_next;
    logic [AW-1:0]     init_cnt_reg, init_cnt_next;

    logic              v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic [ID_W-1:0]   id1_reg, id2_reg, id3_reg, m_id_reg;
    logic [DIST_W-1:0] m_dist_reg, dist_next;
    logic              en1, en2, en3, en4;
    logic              accept, is_write;

    logic [ID_W-1:0]    in_id;
    logic [CODES_W-1:0] in_codes_lo, in_codes_hi;
    logic [TSEL_W-1:0]  in_tsel;
    logic [EIDX_W-1:0]  in_eidx;
    logic [ENTRY_W-1:0] in_eval;
    logic               entry_in_range;

    logic [ENTRY_W-1:0] rd_data [NSQ];
    logic [ENTRY_W-1:0] rd_pad  [G1*4];
    logic [L1_W-1:0]    l1_reg  [G1];
    logic [L1_W-1:0]    l1_next [G1];
    logic [L1_W-1:0]    l1_pad  [G2*4];
    logic [L2_W-1:0]    l2_reg  [G2];
    logic [L2_W-1:0]    l2_next [G2];
    logic [L2_W-1:0]    l2_pad  [4];
    logic [L3_W-1:0]    l3_sum;

    assign in_id       = s_tdata[S_ID_LSB   +: ID_W];
    assign in_codes_lo = s_tdata[S_CLO_LSB  +: CODES_W];
    assign in_codes_hi = s_tdata[S_CHI_LSB  +: CODES_W];
    assign in_tsel     = s_tdata[S_TSEL_LSB +: TSEL_W];
    assign in_eidx     = s_tdata[S_EIDX_LSB +: EIDX_W];
    assign in_eval     = s_tdata[S_EVAL_LSB +: ENTRY_W];

    assign en4      = !m_valid_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = !init_busy_reg && en1;
    assign accept   = s_tvalid && s_tready;
    assign is_write = accept && (s_tuser == OP_WRITE);
    assign entry_in_range = int'(in_eidx) < CODES_PER_TABLE;

    always_comb begin
        init_busy_next = init_busy_reg;
        init_cnt_next  = init_cnt_reg;
        if (init_busy_reg) begin
            init_cnt_next = init_cnt_reg + AW'(1);
            if (init_cnt_reg == AW'(CODES_PER_TABLE - 1)) begin
                init_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_busy_reg <= 1'b1;
            init_cnt_reg  <= '0;
        end else begin
            init_busy_reg <= init_busy_next;
            init_cnt_reg  <= init_cnt_next;
        end
    end

    for (genvar s = 0; s < NSQ; s++) begin : g_table
        localparam int BIAS = (s % 8) + 256 * (s / 8);
        logic [CODE_W-1:0]  code;
        logic [AW-1:0]      rd_addr, wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               wr_en;

        if (s < CODES_PER_WORD) begin : g_lo
            assign code = in_codes_lo[s*CODE_W +: CODE_W];
        end else if (s < 2 * CODES_PER_WORD) begin : g_hi
            assign code = in_codes_hi[(s-CODES_PER_WORD)*CODE_W +: CODE_W];
        end else begin : g_none
            assign code = '0;
        end

        always_comb begin
            if (int'(code) >= CODES_PER_TABLE) begin
                rd_addr = AW'(CODES_PER_TABLE - 1);
            end else begin
                rd_addr = code[AW-1:0];
            end
            if (init_busy_reg) begin
                wr_en   = 1'b1;
                wr_addr = init_cnt_reg;
                wr_data = {INT_W'(BIAS) + INT_W'(init_cnt_reg), {FRAC_W{1'b0}}};
            end else begin
                wr_en   = is_write && (int'(in_tsel) == s) && entry_in_range;
                wr_addr = in_eidx[AW-1:0];
                wr_data = in_eval;
            end
        end

        pqd_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (CODES_PER_TABLE)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (en1),
            .rd_addr (rd_addr),
            .rd_data (rd_data[s])
        );
    end

    for (genvar i = 0; i < G1*4; i++) begin : g_pad0
        if (i < NSQ) begin : g_use
            assign rd_pad[i] = rd_data[i];
        end else begin : g_zero
            assign rd_pad[i] = '0;
        end
    end

    for (genvar i = 0; i < G2*4; i++) begin : g_pad1
        if (i < G1) begin : g_use
            assign l1_pad[i] = l1_reg[i];
        end else begin : g_zero
            assign l1_pad[i] = '0;
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_pad2
        if (i < G2) begin : g_use
            assign l2_pad[i] = l2_reg[i];
        end else begin : g_zero
            assign l2_pad[i] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < G1; g++) begin
            l1_next[g] = L1_W'(rd_pad[4*g]) + L1_W'(rd_pad[4*g+1])
                       + L1_W'(rd_pad[4*g+2]) + L1_W'(rd_pad[4*g+3]);
        end
        for (int g = 0; g < G2; g++) begin
            l2_next[g] = L2_W'(l1_pad[4*g]) + L2_W'(l1_pad[4*g+1])
                       + L2_W'(l1_pad[4*g+2]) + L2_W'(l1_pad[4*g+3]);
        end
        l3_sum = L3_W'(l2_pad[0]) + L3_W'(l2_pad[1])
               + L3_W'(l2_pad[2]) + L3_W'(l2_pad[3]);
        if (|l3_sum[L3_W-1:DIST_W]) begin
            dist_next = '1;
        end else begin
            dist_next = l3_sum[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= accept && (s_tuser == OP_LOOKUP);
            if (en2) v2_reg      <= v1_reg;
            if (en3) v3_reg      <= v2_reg;
            if (en4) m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            id1_reg <= in_id;
        end
        if (en2) begin
            id2_reg <= id1_reg;
            for (int g = 0; g < G1; g++) begin
                l1_reg[g] <= l1_next[g];
            end
        end
        if (en3) begin
            id3_reg <= id2_reg;
            for (int g = 0; g < G2; g++) begin
                l2_reg[g] <= l2_next[g];
            end
        end
        if (en4) begin
            m_id_reg   <= id3_reg;
            m_dist_reg <= dist_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, m_dist_reg, m_id_reg};

endmodule

`default_nettype wire

@@ sv/pqd_checker.sv @@
// Port-level assertions for pq_distance_lookup_sum, attached by bind.
// Uses pqd_pkg.
`default_nettype none

module pqd_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pqd_pkg::M_TDATA_W-1:0] m_tdata
);

    import pqd_pkg::*;

    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    a_reset_fill_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input taken while table fill runs");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:M_USED_W] == '0))
        else $error("result padding bits not zero");

endmodule

bind pq_distance_lookup_sum pqd_checker u_checker (.*);

`default_nettype wire

@@ tb/tb_pq_distance_lookup_sum.sv @@
// Self-checking testbench for pq_distance_lookup_sum: directed and random table
// writes and distance lookups, with a scoreboard class that predicts each sum.
// Depends on pqd_pkg and the pq_distance_lookup_sum RTL.
`timescale 1ns / 1ps

module tb_pq_distance_lookup_sum;
    import pqd_pkg::*;

    localparam int NSQ       = NUM_SUBQUANTIZERS_DEF;
    localparam int CPT       = CODES_PER_TABLE_DEF;
    localparam int NUM_RAND  = 1250;
    localparam int LIMIT     = 300000;
    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    class dist_scoreboard;
        typedef struct packed {
            logic [ID_W-1:0]   id;
            logic [DIST_W-1:0] dsum;
        } dist_result_t;

        logic [ENTRY_W-1:0] tables [NSQ][CPT];
        dist_result_t       due_q[$];
        int                 errors;
        int                 lookups;
        int                 writes;
        int                 results;

        function new();
            logic [ENTRY_W-1:0] bias;
            errors  = 0;
            lookups = 0;
            writes  = 0;
            results = 0;
            for (int s = 0; s < NSQ; s++) begin
                bias = (s % 8) + 256 * (s / 8);
                for (int c = 0; c < CPT; c++)
                    tables[s][c] = (bias + c) << FRAC_W;
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void note_input(pqd_op_t op, logic [ID_W-1:0] id,
                                 logic [2*CODES_W-1:0] codes, logic [TSEL_W-1:0] tsel,
                                 logic [EIDX_W-1:0] eidx, logic [ENTRY_W-1:0] eval);
            logic [DIST_W:0] acc;
            int              code;
            dist_result_t    r;
            if (op == OP_WRITE) begin
                writes++;
                if (tsel < NSQ && eidx < CPT)
                    tables[tsel][eidx] = eval;
                return;
            end
            lookups++;
            acc = '0;
            for (int s = 0; s < NSQ; s++) begin
                code = (s < 2 * CODES_PER_WORD) ? codes[CODE_W*s +: CODE_W] : 0;
                if (code >= CPT)
                    code = CPT - 1;
                acc += tables[s][code];
            end
            r.id   = id;
            r.dsum = (acc > DIST_SAT) ? DIST_SAT : acc[DIST_W-1:0];
            due_q.push_back(r);
        endfunction

        task check_result(logic [ID_W-1:0] id, logic [DIST_W-1:0] dsum);
            dist_result_t r;
            results++;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected result id=%h distance=%h", id, dsum));
            end else begin
                r = due_q.pop_front();
                if (id !== r.id)
                    report($sformatf("result_id %h, want %h", id, r.id));
                if (dsum !== r.dsum)
                    report($sformatf("distance %h, want %h (id %h)", dsum, r.dsum, r.id));
            end
        endtask

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    dist_scoreboard        sb;
    int                    cycle_count = 0;
    int                    rx_wait     = 0;
    bit                    rx_calm     = 1'b0;
    bit                    tx_calm     = 1'b0;
    logic [EIDX_W-1:0]     hot [4]     = '{8'd0, 8'd255, 8'd1, 8'd128};

    pq_distance_lookup_sum dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_pq_distance_lookup_sum: errors");
            $finish;
        end
    end

    // result side: check each transaction, then stall for a random count unless rx_calm is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_wait = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata[M_ID_LSB +: ID_W], m_tdata[M_DIST_LSB +: DIST_W]);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    task automatic send_item(pqd_op_t op, logic [ID_W-1:0] id, logic [2*CODES_W-1:0] codes,
                             logic [TSEL_W-1:0] tsel, logic [EIDX_W-1:0] eidx,
                             logic [ENTRY_W-1:0] eval, int gap);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[S_ID_LSB   +: ID_W]    = id;
        d[S_CLO_LSB  +: CODES_W] = codes[CODES_W-1:0];
        d[S_CHI_LSB  +: CODES_W] = codes[2*CODES_W-1:CODES_W];
        d[S_TSEL_LSB +: TSEL_W]  = tsel;
        d[S_EIDX_LSB +: EIDX_W]  = eidx;
        d[S_EVAL_LSB +: ENTRY_W] = eval;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, id, codes, tsel, eidx, eval);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop valid and hold until every pending lookup has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        pqd_op_t              op;
        logic [ID_W-1:0]      id;
        logic [2*CODES_W-1:0] codes;
        logic [TSEL_W-1:0]    tsel;
        logic [EIDX_W-1:0]    eidx;
        logic [ENTRY_W-1:0]   eval;
        int                   gap;

        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset pattern at both ends and the middle of every table
        send_item(OP_LOOKUP, '0, '0, '0, '0, '0, 0);
        send_item(OP_LOOKUP, '1, '1, '1, '1, '1, 2);
        send_item(OP_LOOKUP, 32'h1234_5678, {16{8'h80}}, '0, '0, '0, 0);
        // all-ones entries at code 255 give the largest possible sum
        for (int s = 0; s < NSQ; s++)
            send_item(OP_WRITE, 32'hdead_0000 | s, '1, TSEL_W'(s), 8'hff, '1, 0);
        send_item(OP_LOOKUP, 32'hffff_0001, '1, '0, '0, '0, 0);
        // write followed at once by a lookup of the same entry
        send_item(OP_WRITE, '0, '0, 4'd0, 8'd0, '0, 0);
        send_item(OP_LOOKUP, 32'h0000_0002, '0, '1, '1, '1, 0);
        send_item(OP_WRITE, '1, '1, 4'd15, 8'd0, 32'h8000_0001, 0);
        send_item(OP_LOOKUP, 32'haaaa_5555, '0, '0, '0, '0, 3);

        drain_results();

        for (int n = 0; n < NUM_RAND; n++) begin
            if (n % 100 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (n == NUM_RAND / 2)
                drain_results();
            op    = ($urandom_range(0, 9) < 3) ? OP_WRITE : OP_LOOKUP;
            id    = $urandom;
            codes = {$urandom, $urandom, $urandom, $urandom};
            tsel  = TSEL_W'($urandom_range(0, 15));
            eidx  = EIDX_W'($urandom_range(0, 255));
            eval  = $urandom;
            if (op == OP_WRITE) begin
                if ($urandom_range(0, 1))
                    eidx = hot[$urandom_range(0, 3)];
                case ($urandom_range(0, 7))
                    0: eval = '0;
                    1: eval = '1;
                    default: ;
                endcase
                hot[$urandom_range(0, 3)] = eidx;
            end else if ($urandom_range(0, 1)) begin
                for (int k = 0; k < 2 * CODES_PER_WORD; k++)
                    codes[CODE_W*k +: CODE_W] = hot[$urandom_range(0, 3)];
            end
            gap = tx_calm ? 0 : $urandom_range(0, 10);
            send_item(op, id, codes, tsel, eidx, eval, gap);
        end

        drain_results();
        if (sb.pending() > 0)
            sb.report($sformatf("%0d lookups never returned", sb.pending()));

        $display("covered %0d lookups and %0d table writes, %0d results checked",
                 sb.lookups, sb.writes, sb.results);
        $display("includes reset pattern, saturated tables and write-then-lookup hazards");
        if (sb.errors == 0) begin
            $display("tb_pq_distance_lookup_sum: clean");
        end else begin
            $display("tb_pq_distance_lookup_sum: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/pqd_pkg.sv
sv/pqd_ram.sv
sv/pq_distance_lookup_sum.sv
sv/pqd_checker.sv
tb/tb_pq_distance_lookup_sum.sv
